[hw/rtl/sorted_alarm_timer_queue_unit_assert.svh]
// Assertion macros for the sorted alarm timer queue unit.
// Taken in by the top level with an include; no other dependencies.
`ifndef SORTED_ALARM_TIMER_QUEUE_UNIT_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SATQ_ASSERT_SAME(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("satq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SATQ_ASSERT_NEXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("satq: next-cycle check failed");

`endif

[hw/rtl/satq_pkg.sv]
// Shared types and constants for the sorted alarm timer queue unit.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package satq_pkg;

	localparam int DEPTH_DEF    = 16;
	localparam int ID_WIDTH_DEF = 4;
	localparam int TIME_W       = 64;
	localparam int ID_PORT_W    = 4;
	localparam int KIND_W       = 3;

	localparam logic [KIND_W-1:0] KIND_QUEUED    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PAST      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_WOKEN     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd4;

	localparam logic OP_SLEEP = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Chain-wide command: insert in order, or shift everything toward the head.
	typedef struct packed {
		logic ins;
		logic pop;
	} satq_ctl_t;

endpackage

[hw/rtl/satq_if.sv]
// Valid/ready channel interfaces for request and result items.
// Depends on satq_pkg for field widths.
`timescale 1ns / 1ps

interface satq_req_if import satq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [ID_PORT_W-1:0] alarm_id;
	logic [TIME_W-1:0]    start_time;
	logic [TIME_W-1:0]    increment;
	logic [TIME_W-1:0]    current_time;

	modport source (output valid, operation, alarm_id, start_time, increment,
		current_time, input ready);
	modport sink (input valid, operation, alarm_id, start_time, increment,
		current_time, output ready);
endinterface

interface satq_rsp_if import satq_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [KIND_W-1:0]    kind;
	logic [ID_PORT_W-1:0] result_id;
	logic [TIME_W-1:0]    wake_time;
	logic [TIME_W-1:0]    compare_value;
	logic                 interrupt_enable;
	logic                 last;

	modport source (output valid, kind, result_id, wake_time, compare_value,
		interrupt_enable, last, input ready);
	modport sink (input valid, kind, result_id, wake_time, compare_value,
		interrupt_enable, last, output ready);
endinterface

[hw/rtl/satq_cell.sv]
// One slot of the sorted alarm chain: wake time and id, with neighbor shifting.
// Depends on satq_pkg for the chain command struct and the time width.
`timescale 1ns / 1ps

module satq_cell import satq_pkg::*; #(
	parameter int ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic                clk,
	input  satq_ctl_t           ctl,
	input  logic                occupied,
	input  logic [TIME_W-1:0]   new_wake,
	input  logic [ID_WIDTH-1:0] new_id,
	input  logic                prev_after,
	input  logic [TIME_W-1:0]   prev_wake,
	input  logic [ID_WIDTH-1:0] prev_id,
	input  logic [TIME_W-1:0]   next_wake,
	input  logic [ID_WIDTH-1:0] next_id,
	output logic                after,
	output logic [TIME_W-1:0]   wake,
	output logic [ID_WIDTH-1:0] id
);

	logic [TIME_W-1:0]   wake_q;
	logic [ID_WIDTH-1:0] id_q;

	// Strictly greater keeps equal wake times in arrival order.
	assign after = !occupied || (wake_q > new_wake);
	assign wake  = wake_q;
	assign id    = id_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && after) begin
			if (prev_after) begin
				wake_q <= prev_wake;
				id_q   <= prev_id;
			end else begin
				wake_q <= new_wake;
				id_q   <= new_id;
			end
		end else if (ctl.pop) begin
			wake_q <= next_wake;
			id_q   <= next_id;
		end
	end

endmodule

[hw/rtl/sorted_alarm_timer_queue_unit.sv]
// Sorted alarm timer queue: a sleep request has its sum registered at acceptance, then is compared and inserted.
// A tick is accepted, then gives one woken item per due alarm and a final done item;
// the head cell pops one alarm per cycle while the output register is free. Items are taken one at a time.
// Each result waits in an output register; a stalled sink holds the unit in place.
// Reset empties the queue, sets the compare register to all ones and clears the enable.
`timescale 1ns / 1ps
`include "sorted_alarm_timer_queue_unit_assert.svh"

module sorted_alarm_timer_queue_unit import satq_pkg::*; #(
	parameter int DEPTH    = DEPTH_DEF,
	parameter int ID_WIDTH = ID_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	satq_req_if.sink  req,
	satq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SLEEP = 3'b010,
		ST_TICK  = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [TIME_W-1:0]   cmp_q, cmp_d;
	logic                irq_q, irq_d;
	logic [TIME_W-1:0]   wake_q, now_q;
	logic [ID_WIDTH-1:0] id_q;
	logic [TIME_W:0]     sum;

	logic                out_valid_q, out_free, load_out;
	logic [KIND_W-1:0]   kind_q, o_kind;
	logic [ID_PORT_W-1:0] rid_q, o_id;
	logic [TIME_W-1:0]   owake_q, o_wake, ocmp_q;
	logic                oirq_q, last_q, o_last;

	satq_ctl_t           ctl;
	logic [TIME_W-1:0]   wake_c [DEPTH];
	logic [ID_WIDTH-1:0] id_c [DEPTH];
	logic [DEPTH-1:0]    after_c, occ_c;
	logic                head_valid, head_due, full, past;

	// Saturating wake time, registered at acceptance.
	assign sum = {1'b0, req.start_time} + {1'b0, req.increment};

	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_due   = head_valid && (wake_c[0] <= now_q);
	assign past       = (wake_q < now_q);
	assign out_free   = !out_valid_q || rsp.ready;
	assign req.ready  = (state_q == ST_IDLE);

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic                pa;
			logic [TIME_W-1:0]   pw, nw;
			logic [ID_WIDTH-1:0] pi, ni;

			assign occ_c[i] = (count_q > CNT_W'(i));
			if (i == 0) begin : g_first
				assign pa = 1'b0;
				assign pw = '0;
				assign pi = '0;
			end else begin : g_mid
				assign pa = after_c[i-1];
				assign pw = wake_c[i-1];
				assign pi = id_c[i-1];
			end
			if (i == DEPTH - 1) begin : g_last
				assign nw = '0;
				assign ni = '0;
			end else begin : g_inner
				assign nw = wake_c[i+1];
				assign ni = id_c[i+1];
			end

			satq_cell #(.ID_WIDTH(ID_WIDTH)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.occupied  (occ_c[i]),
				.new_wake  (wake_q),
				.new_id    (id_q),
				.prev_after(pa),
				.prev_wake (pw),
				.prev_id   (pi),
				.next_wake (nw),
				.next_id   (ni),
				.after     (after_c[i]),
				.wake      (wake_c[i]),
				.id        (id_c[i])
			);
		end
	endgenerate

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cmp_d    = cmp_q;
		irq_d    = irq_q;
		ctl      = '0;
		load_out = 1'b0;
		o_kind   = KIND_TICK_DONE;
		o_id     = '0;
		o_wake   = '0;
		o_last   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.operation == OP_TICK) ? ST_TICK : ST_SLEEP;
				end
			end
			ST_SLEEP: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
					o_id     = ID_PORT_W'(id_q);
					o_wake   = wake_q;
					if (past) begin
						o_kind = KIND_PAST;
					end else if (full) begin
						o_kind = KIND_DROPPED;
					end else begin
						o_kind  = KIND_QUEUED;
						ctl.ins = 1'b1;
						count_d = count_q + 1'b1;
						irq_d   = 1'b1;
						// Landing in front of every stored alarm makes a new head.
						if (after_c[0]) begin
							cmp_d = wake_q;
						end
					end
				end
			end
			ST_TICK: begin
				if (out_free) begin
					load_out = 1'b1;
					if (head_due) begin
						o_kind  = KIND_WOKEN;
						o_id    = ID_PORT_W'(id_c[0]);
						o_wake  = wake_c[0];
						o_last  = 1'b0;
						ctl.pop = 1'b1;
						count_d = count_q - 1'b1;
					end else begin
						state_d = ST_IDLE;
						if (head_valid) begin
							cmp_d = wake_c[0];
							irq_d = 1'b1;
						end else begin
							irq_d = 1'b0;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cmp_q       <= '1;
			irq_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cmp_q   <= cmp_d;
			irq_q   <= irq_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			wake_q <= sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			now_q  <= req.current_time;
			id_q   <= ID_WIDTH'(req.alarm_id);
		end
		if (load_out) begin
			kind_q  <= o_kind;
			rid_q   <= o_id;
			owake_q <= o_wake;
			ocmp_q  <= cmp_d;
			oirq_q  <= irq_d;
			last_q  <= o_last;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.kind             = kind_q;
	assign rsp.result_id        = rid_q;
	assign rsp.wake_time        = owake_q;
	assign rsp.compare_value    = ocmp_q;
	assign rsp.interrupt_enable = oirq_q;
	assign rsp.last             = last_q;

	`SATQ_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`SATQ_ASSERT_SAME(a_ins_not_full, clk, arst_n, ctl.ins, !full && !ctl.pop)
	`SATQ_ASSERT_SAME(a_pop_due, clk, arst_n, ctl.pop, head_valid && wake_c[0] <= now_q)
	`SATQ_ASSERT_NEXT(a_result_held, clk, arst_n, load_out, out_valid_q)

endmodule

[bench/testbench.sv]
// Self-checking bench for the sorted alarm timer queue unit: directed cases, then random traffic.
// Needs satq_pkg, the satq_req_if / satq_rsp_if channel interfaces and the unit's top level.
`timescale 1ns / 1ps

module testbench;
	import satq_pkg::*;

	localparam int CYCLE_LIMIT = 800_000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [ID_PORT_W-1:0] ID_MASK = ID_PORT_W'((1 << ID_WIDTH_DEF) - 1);
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	typedef struct {
		logic                 operation;
		logic [ID_PORT_W-1:0] alarm_id;
		logic [TIME_W-1:0]    start_time;
		logic [TIME_W-1:0]    increment;
		logic [TIME_W-1:0]    current_time;
	} alarm_req_t;

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic [ID_PORT_W-1:0] result_id;
		logic [TIME_W-1:0]    wake_time;
		logic [TIME_W-1:0]    compare_value;
		logic                 interrupt_enable;
		logic                 last;
	} alarm_rsp_t;

	logic clk;
	logic arst_n;

	satq_req_if req ();
	satq_rsp_if rsp ();

	sorted_alarm_timer_queue_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow of the unit's state, advanced on every accepted item.
	logic [TIME_W-1:0]    alarm_times [DEPTH_DEF];
	logic [ID_PORT_W-1:0] alarm_ids [DEPTH_DEF];
	int                   alarm_count;
	logic [TIME_W-1:0]    shadow_compare;
	logic                 shadow_irq_en;

	alarm_rsp_t           expected_results [$];
	int                   errors;
	int                   cycles;
	bit                   calm;
	int                   hold_requests;
	logic [TIME_W-1:0]    clock_now;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void post_alarm_result(input logic [KIND_W-1:0] kind,
			input logic [ID_PORT_W-1:0] id, input logic [TIME_W-1:0] wake, input logic last);
		alarm_rsp_t r;
		r.kind             = kind;
		r.result_id        = id;
		r.wake_time        = wake;
		r.compare_value    = shadow_compare;
		r.interrupt_enable = shadow_irq_en;
		r.last             = last;
		expected_results.push_back(r);
	endfunction

	task automatic predict_results(input alarm_req_t r);
		logic [TIME_W:0]      sum;
		logic [TIME_W-1:0]    wake;
		logic [ID_PORT_W-1:0] id;
		int                   pos;
		int                   popped;
		id = r.alarm_id & ID_MASK;
		if (r.operation == OP_SLEEP) begin
			sum  = {1'b0, r.start_time} + {1'b0, r.increment};
			wake = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
			if (wake < r.current_time) begin
				post_alarm_result(KIND_PAST, id, wake, 1'b1);
			end else if (alarm_count >= DEPTH_DEF) begin
				post_alarm_result(KIND_DROPPED, id, wake, 1'b1);
			end else begin
				// Equal wake times go behind the ones already queued.
				pos = 0;
				while (pos < alarm_count && alarm_times[pos] <= wake)
					pos++;
				for (int i = alarm_count; i > pos; i--) begin
					alarm_times[i] = alarm_times[i-1];
					alarm_ids[i]   = alarm_ids[i-1];
				end
				alarm_times[pos] = wake;
				alarm_ids[pos]   = id;
				alarm_count++;
				if (pos == 0)
					shadow_compare = wake;
				shadow_irq_en = 1'b1;
				post_alarm_result(KIND_QUEUED, id, wake, 1'b1);
			end
		end else if (alarm_count == 0) begin
			shadow_irq_en = 1'b0;
			post_alarm_result(KIND_TICK_DONE, '0, '0, 1'b1);
		end else begin
			popped = 0;
			while (popped < alarm_count && alarm_times[popped] <= r.current_time) begin
				post_alarm_result(KIND_WOKEN, alarm_ids[popped], alarm_times[popped], 1'b0);
				popped++;
			end
			for (int i = popped; i < alarm_count; i++) begin
				alarm_times[i-popped] = alarm_times[i];
				alarm_ids[i-popped]   = alarm_ids[i];
			end
			alarm_count -= popped;
			if (alarm_count > 0) begin
				shadow_compare = alarm_times[0];
				shadow_irq_en  = 1'b1;
			end else begin
				shadow_irq_en = 1'b0;
			end
			post_alarm_result(KIND_TICK_DONE, '0, '0, 1'b1);
		end
	endtask

	// Every accepted result is compared with the oldest outstanding expectation.
	always @(posedge clk) begin : check_results
		alarm_rsp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: kind %0d id %0d", rsp.kind, rsp.result_id);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (rsp.kind !== want.kind) begin
					$error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
					errors++;
				end
				if (rsp.result_id !== want.result_id) begin
					$error("result_id: expected %0d, actual %0d", want.result_id, rsp.result_id);
					errors++;
				end
				if (rsp.wake_time !== want.wake_time) begin
					$error("wake_time: expected %h, actual %h", want.wake_time, rsp.wake_time);
					errors++;
				end
				if (rsp.compare_value !== want.compare_value) begin
					$error("compare_value: expected %h, actual %h", want.compare_value,
						rsp.compare_value);
					errors++;
				end
				if (rsp.interrupt_enable !== want.interrupt_enable) begin
					$error("interrupt_enable: expected %0b, actual %0b", want.interrupt_enable,
						rsp.interrupt_enable);
					errors++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, rsp.last);
					errors++;
				end
			end
		end
	end

	// Result side: random stall bursts, plus a long hold-off whenever a test asks for one.
	initial begin : drive_result_ready
		int hold_served;
		int hold_left;
		int stall_left;
		hold_served = 0;
		hold_left   = 0;
		stall_left  = 0;
		rsp.ready   = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp.ready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp.ready = 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				rsp.ready  = 1'b0;
				stall_left = $urandom_range(1, 15) - 1;
			end else begin
				rsp.ready = 1'b1;
			end
		end
	end

	function automatic alarm_req_t sleep_item(input logic [ID_PORT_W-1:0] id,
			input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] inc,
			input logic [TIME_W-1:0] now);
		alarm_req_t r;
		r.operation    = OP_SLEEP;
		r.alarm_id     = id;
		r.start_time   = start;
		r.increment    = inc;
		r.current_time = now;
		return r;
	endfunction

	function automatic alarm_req_t tick_item(input logic [TIME_W-1:0] now);
		alarm_req_t r;
		r.operation    = OP_TICK;
		r.alarm_id     = 4'($urandom_range(0, 15));
		r.start_time   = {$urandom, $urandom};
		r.increment    = {$urandom, $urandom};
		r.current_time = now;
		return r;
	endfunction

	task automatic send_request(input alarm_req_t r);
		@(negedge clk);
		req.operation    = r.operation;
		req.alarm_id     = r.alarm_id;
		req.start_time   = r.start_time;
		req.increment    = r.increment;
		req.current_time = r.current_time;
		req.valid        = 1'b1;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		predict_results(r);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		req.valid = 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	task automatic wait_for_results();
		pause_sender(1);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_tick();
		send_request(tick_item('0));
		wait_for_results();
	endtask

	// Saturating sum, wake time equal to now, a request already past, and a zero wake time.
	task automatic test_wake_time_edges();
		send_request(sleep_item(4'd15, TIME_MAX, 64'd5, '0));
		send_request(sleep_item(4'd0, 64'd100, '0, 64'd100));
		send_request(sleep_item(4'd7, 64'd10, 64'd5, 64'd16));
		send_request(sleep_item(4'd1, '0, '0, '0));
		wait_for_results();
	endtask

	// Equal wake times must leave in arrival order; the last tick empties the queue.
	task automatic test_stable_order();
		send_request(sleep_item(4'd3, 64'd150, 64'd50, 64'd20));
		send_request(sleep_item(4'd12, 64'd199, 64'd1, 64'd20));
		send_request(tick_item(64'd150));
		send_request(tick_item(TIME_MAX));
		wait_for_results();
	endtask

	// The result side holds off while more alarms than the queue's depth are sent, so the unit
	// backs up onto its input; a full tick then wakes every alarm.
	task automatic test_full_queue();
		hold_requests++;
		for (int i = 0; i < DEPTH_DEF + 1; i++)
			send_request(sleep_item(4'($urandom_range(0, 15)), 64'($urandom_range(0, 40)),
				64'($urandom_range(0, 40)), '0));
		send_request(sleep_item(4'd9, '0, '0, 64'd1));
		send_request(tick_item(TIME_MAX));
		wait_for_results();
	endtask

	// Mostly a coherent timeline: sleeps relative to a running clock and ticks that advance
	// it, with some fully random items and jumps close to the top of the time range.
	task automatic test_random_traffic(input int count);
		alarm_req_t r;
		int         pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				r = sleep_item(4'($urandom_range(0, 15)), clock_now - $urandom_range(0, 50),
					64'($urandom_range(0, 300)), clock_now);
			end else if (pick < 85) begin
				clock_now = clock_now + $urandom_range(0, 120);
				r = tick_item(clock_now);
			end else if (pick < 92) begin
				r = sleep_item(4'($urandom_range(0, 15)), {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			end else if (pick < 96) begin
				r = tick_item({$urandom, $urandom});
			end else begin
				clock_now = TIME_MAX - $urandom_range(0, 400);
				r = sleep_item(4'($urandom_range(0, 15)), clock_now,
					64'($urandom_range(0, 800)), clock_now);
			end
			if (!calm && $urandom_range(0, 7) == 0)
				pause_sender($urandom_range(1, 15));
			send_request(r);
		end
		wait_for_results();
	endtask

	initial begin
		arst_n           = 1'b0;
		req.valid        = 1'b0;
		req.operation    = OP_SLEEP;
		req.alarm_id     = '0;
		req.start_time   = '0;
		req.increment    = '0;
		req.current_time = '0;
		calm             = 1'b0;
		errors           = 0;
		cycles           = 0;
		hold_requests    = 0;
		alarm_count      = 0;
		shadow_compare   = TIME_MAX;
		shadow_irq_en    = 1'b0;
		clock_now        = {$urandom, $urandom};
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_tick();
		test_wake_time_edges();
		test_stable_order();
		test_full_queue();
		test_random_traffic(250);
		calm = 1'b1;
		test_random_traffic(150);

		wait_for_results();
		repeat (40)
			@(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
